[rtl/core/grid_neighborhood_csr_generator_unit_macros.svh]
// assertion helpers shared by the generator rtl
`ifndef GRID_NEIGHBORHOOD_CSR_GENERATOR_UNIT_MACROS_SVH
`define GRID_NEIGHBORHOOD_CSR_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define GNCSR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define GNCSR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gncsr_pkg.sv]
`default_nettype none

package gncsr_pkg;

  // field and register widths
  localparam int IDX_W      = 16;
  localparam int OFF_W      = 22;
  localparam int SIDE_CFG_W = 9;
  localparam int RAD_CFG_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIDE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS    = 1'd1;

  // register reset values
  localparam logic [SIDE_CFG_W-1:0] SIDE_RESET   = 9'd16;
  localparam logic [RAD_CFG_W-1:0]  RADIUS_RESET = 2'd1;

  // sequencer step addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] STEP_ACCEPT = 3'd0;
  localparam logic [PC_W-1:0] STEP_SQUARE = 3'd1;
  localparam logic [PC_W-1:0] STEP_CHECK  = 3'd2;
  localparam logic [PC_W-1:0] STEP_DIV    = 3'd3;
  localparam logic [PC_W-1:0] STEP_BOUNDS = 3'd4;
  localparam logic [PC_W-1:0] STEP_BASE   = 3'd5;
  localparam logic [PC_W-1:0] STEP_SCAN   = 3'd6;
  localparam logic [PC_W-1:0] STEP_DONE   = 3'd7;

  // datapath actions
  localparam int ACT_W = 3;
  localparam logic [ACT_W-1:0] ACT_ACCEPT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SQUARE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CHECK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DIV    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_BOUNDS = 3'd4;
  localparam logic [ACT_W-1:0] ACT_BASE   = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SCAN   = 3'd6;
  localparam logic [ACT_W-1:0] ACT_NOP    = 3'd7;

  // jump conditions
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_NONE   = 2'd0;
  localparam logic [COND_W-1:0] COND_ALWAYS = 2'd1;
  localparam logic [COND_W-1:0] COND_BAD    = 2'd2;
  localparam logic [COND_W-1:0] COND_MORE   = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  act;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   target;
  } uop_t;

  // control store
  function automatic uop_t ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      STEP_ACCEPT: u = '{act: ACT_ACCEPT, cond: COND_NONE,   target: STEP_ACCEPT};
      STEP_SQUARE: u = '{act: ACT_SQUARE, cond: COND_NONE,   target: STEP_ACCEPT};
      STEP_CHECK:  u = '{act: ACT_CHECK,  cond: COND_BAD,    target: STEP_ACCEPT};
      STEP_DIV:    u = '{act: ACT_DIV,    cond: COND_MORE,   target: STEP_DIV};
      STEP_BOUNDS: u = '{act: ACT_BOUNDS, cond: COND_NONE,   target: STEP_ACCEPT};
      STEP_BASE:   u = '{act: ACT_BASE,   cond: COND_NONE,   target: STEP_ACCEPT};
      STEP_SCAN:   u = '{act: ACT_SCAN,   cond: COND_MORE,   target: STEP_SCAN};
      default:     u = '{act: ACT_NOP,    cond: COND_ALWAYS, target: STEP_ACCEPT};
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

[rtl/core/gncsr_in_if.sv]
`default_nettype none

interface gncsr_in_if;
  import gncsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

`default_nettype wire

[rtl/core/gncsr_out_if.sv]
`default_nettype none

interface gncsr_out_if;
  import gncsr_pkg::*;

  logic             valid;
  logic             ready;
  logic [OFF_W-1:0] cell_offset;
  logic [IDX_W-1:0] neighbor_index;
  logic             neighbor_valid;
  logic             index_error;
  logic             last;

  modport source (output valid, output cell_offset, output neighbor_index,
                  output neighbor_valid, output index_error, output last,
                  input ready);
  modport sink   (input valid, input cell_offset, input neighbor_index,
                  input neighbor_valid, input index_error, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/grid_neighborhood_csr_generator_unit.sv]
// Moore neighborhood generator in CSR form.
// in_ch carries one cell index per word; out_ch returns one word per neighbor,
// row-major, each tagged with the cell's CSR offset, with last on the final one.
// An out-of-range index or an empty neighborhood gives a single word with
// neighbor_valid low. A zero index restarts the running offset.
// Configuration (grid_side, radius) goes in through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the block is idle, as the block itself does
// not enforce this. Both saturate at MAX_SIDE and MAX_RADIUS. A small microcoded
// sequencer runs each cell: accept, square, range check, a 16-step restoring
// divider for row and column, window setup, then one window position per cycle
// unless the receiver stalls. in_ch.ready is high only in the accept step, out
// of reset. A stalled receiver holds the output register and the scan waits on
// it; no word is dropped. Synchronous reset clears the sequencer, the running
// count and the output valid, and loads grid_side 16 and radius 1.
`default_nettype none
`include "grid_neighborhood_csr_generator_unit_macros.svh"

module grid_neighborhood_csr_generator_unit #(
  parameter int MAX_SIDE   = 256,
  parameter int MAX_RADIUS = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  gncsr_in_if.sink                          in_ch,
  gncsr_out_if.source                       out_ch,
  input  logic                              cfg_we,
  input  logic [gncsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gncsr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import gncsr_pkg::*;

  localparam int SAT_SIDE = (MAX_SIDE < 511) ? MAX_SIDE : 511;
  localparam int CW       = $clog2(SAT_SIDE + 1);
  localparam int RW       = $clog2(MAX_RADIUS + 1);
  localparam int NW       = 2 * CW;
  localparam int CMPW     = (NW > IDX_W) ? NW : IDX_W;
  localparam int DCNT_W   = $clog2(IDX_W);
  localparam logic [CW-1:0]     SAT_SIDE_V = CW'(SAT_SIDE);
  localparam logic [RW-1:0]     MAX_RAD_V  = RW'(MAX_RADIUS);
  localparam logic [DCNT_W-1:0] DCNT_LAST  = DCNT_W'(IDX_W - 1);

  // low window edge clipped at zero
  function automatic logic [CW-1:0] clip_lo(input logic [CW-1:0] c,
                                            input logic [RW-1:0] r);
    logic [CW:0] cw;
    logic [CW:0] rw;
    logic [CW:0] d;
    cw = {1'b0, c};
    rw = (CW + 1)'(r);
    d  = cw - rw;
    return (cw >= rw) ? d[CW-1:0] : '0;
  endfunction

  // high window edge (inclusive) clipped at side - 1
  function automatic logic [CW-1:0] clip_hi(input logic [CW-1:0] c,
                                            input logic [RW-1:0] r,
                                            input logic [CW-1:0] s);
    logic [CW:0] h;
    logic [CW:0] sm1;
    h   = {1'b0, c} + (CW + 1)'(r);
    sm1 = {1'b0, s} - (CW + 1)'(1);
    return (h < sm1) ? h[CW-1:0] : sm1[CW-1:0];
  endfunction

  // configuration and control state
  logic [SIDE_CFG_W-1:0] grid_side_r;
  logic [RAD_CFG_W-1:0]  radius_r;
  logic [PC_W-1:0]       pc_r, pc_nxt;
  logic [OFF_W-1:0]      count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // datapath registers
  logic [IDX_W-1:0]  idx_r;
  logic [CW-1:0]     side_r;
  logic [RW-1:0]     rad_r;
  logic [OFF_W-1:0]  off_r;
  logic [NW-1:0]     prod_r;
  logic [CW-1:0]     rem_r;
  logic [IDX_W-1:0]  quo_r;
  logic [DCNT_W-1:0] dcnt_r;
  logic [CW-1:0]     x_r, x0_r, x1m_r, y_r, y1m_r;
  logic              self_final_r;
  logic [NW-1:0]     base_r;
  logic [OFF_W-1:0]  o_off_r;
  logic [IDX_W-1:0]  o_nb_r;
  logic              o_nbv_r, o_err_r, o_last_r;

  uop_t          uop;
  logic          in_acc, out_free;
  logic [CW-1:0] side_sat;
  logic [RW-1:0] rad_sat;
  logic          bad_range, empty_list, bad;
  logic [CW:0]   rem_sh;
  logic          div_ge;
  logic [CW:0]   rem_sub;
  logic [CW-1:0] col, row, x0, y0, x1m, y1m;
  logic [NW-1:0] nb;
  logic          is_self, row_end, at_final, pre_final, emit_last;
  logic          more, done, take;
  logic          emit_chk, emit_scan;

  assign uop      = ucode(pc_r);
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready           = (uop.act == ACT_ACCEPT) && rst_n;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.cell_offset    = o_off_r;
  assign out_ch.neighbor_index = o_nb_r;
  assign out_ch.neighbor_valid = o_nbv_r;
  assign out_ch.index_error    = o_err_r;
  assign out_ch.last           = o_last_r;

  // saturated configuration
  assign side_sat = (int'(grid_side_r) > SAT_SIDE) ? SAT_SIDE_V : grid_side_r[CW-1:0];
  assign rad_sat  = (int'(radius_r) > MAX_RADIUS) ? MAX_RAD_V : radius_r[RW-1:0];

  // range and empty checks
  assign bad_range  = (side_r == '0) || (CMPW'(idx_r) >= CMPW'(prod_r));
  assign empty_list = (rad_r == '0) || (side_r == CW'(1));
  assign bad        = bad_range || empty_list;

  // restoring divider step
  assign rem_sh  = {rem_r, quo_r[IDX_W-1]};
  assign div_ge  = rem_sh >= {1'b0, side_r};
  assign rem_sub = div_ge ? (rem_sh - {1'b0, side_r}) : rem_sh;

  // window bounds
  assign col = rem_r;
  assign row = quo_r[CW-1:0];
  assign x0  = clip_lo(col, rad_r);
  assign y0  = clip_lo(row, rad_r);
  assign x1m = clip_hi(col, rad_r, side_r);
  assign y1m = clip_hi(row, rad_r, side_r);

  // scan position
  assign nb        = base_r + NW'(x_r);
  assign is_self   = CMPW'(nb) == CMPW'(idx_r);
  assign row_end   = (x_r == x1m_r);
  assign at_final  = row_end && (y_r == y1m_r);
  assign pre_final = (y_r == y1m_r) && (x_r == (x1m_r - CW'(1)));
  assign emit_last = at_final || (self_final_r && pre_final);

  // step completion and jumps
  always_comb begin
    case (uop.act)
      ACT_ACCEPT: done = in_ch.valid;
      ACT_CHECK:  done = !bad || out_free;
      ACT_SCAN:   done = is_self || out_free;
      default:    done = 1'b1;
    endcase
    more = (uop.act == ACT_DIV) ? (dcnt_r != DCNT_LAST) : !at_final;
    take = done && ((uop.cond == COND_ALWAYS) ||
                    ((uop.cond == COND_BAD) && bad) ||
                    ((uop.cond == COND_MORE) && more));
    if (!done) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = uop.target;
    end else begin
      pc_nxt = pc_r + PC_W'(1);
    end
  end

  // result emission and running count
  assign emit_chk  = (uop.act == ACT_CHECK) && bad && out_free;
  assign emit_scan = (uop.act == ACT_SCAN) && !is_self && out_free;

  always_comb begin
    if (emit_chk || emit_scan) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    if (in_acc && (in_ch.cell_index == '0)) begin
      count_nxt = '0;
    end else if (emit_scan) begin
      count_nxt = count_r + OFF_W'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r <= SIDE_RESET;
      radius_r    <= RADIUS_RESET;
      pc_r        <= STEP_ACCEPT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_GRID_SIDE: grid_side_r <= cfg_wdata;
          REG_RADIUS:    radius_r    <= cfg_wdata[RAD_CFG_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  // datapath driven by the current control word
  always_ff @(posedge clk) begin
    case (uop.act)
      ACT_ACCEPT: begin
        if (in_ch.valid) begin
          idx_r  <= in_ch.cell_index;
          side_r <= side_sat;
          rad_r  <= rad_sat;
          off_r  <= (in_ch.cell_index == '0) ? '0 : count_r;
        end
      end
      ACT_SQUARE: begin
        prod_r <= NW'(side_r) * NW'(side_r);
        rem_r  <= '0;
        quo_r  <= idx_r;
        dcnt_r <= '0;
      end
      ACT_DIV: begin
        rem_r  <= rem_sub[CW-1:0];
        quo_r  <= {quo_r[IDX_W-2:0], div_ge};
        dcnt_r <= dcnt_r + DCNT_W'(1);
      end
      ACT_BOUNDS: begin
        x0_r         <= x0;
        x1m_r        <= x1m;
        y1m_r        <= y1m;
        x_r          <= x0;
        y_r          <= y0;
        self_final_r <= (x1m == col) && (y1m == row);
      end
      ACT_BASE: begin
        base_r <= NW'(y_r) * NW'(side_r);
      end
      ACT_SCAN: begin
        if (done) begin
          if (row_end) begin
            x_r    <= x0_r;
            y_r    <= y_r + CW'(1);
            base_r <= base_r + NW'(side_r);
          end else begin
            x_r <= x_r + CW'(1);
          end
        end
      end
      default: ;
    endcase

    // output register
    if (emit_chk) begin
      o_off_r  <= off_r;
      o_nb_r   <= '0;
      o_nbv_r  <= 1'b0;
      o_err_r  <= bad_range;
      o_last_r <= 1'b1;
    end else if (emit_scan) begin
      o_off_r  <= off_r;
      o_nb_r   <= nb[IDX_W-1:0];
      o_nbv_r  <= 1'b1;
      o_err_r  <= 1'b0;
      o_last_r <= emit_last;
    end
  end

  // checks
  `GNCSR_ASSERT_IMPL(a_rem_below_side, clk, rst_n, pc_r == STEP_DIV, rem_r < side_r, "divider remainder not below side")
  `GNCSR_ASSERT_IMPL(a_scan_in_window, clk, rst_n, pc_r == STEP_SCAN, (x_r <= x1m_r) && (y_r <= y1m_r), "scan position outside window")
  `GNCSR_ASSERT_NEXT(a_count_quiet, clk, rst_n, (pc_r != STEP_SCAN) && !in_acc, $stable(count_r), "running count moved outside scan")
  `GNCSR_ASSERT_IMPL(a_err_word_form, clk, rst_n, out_valid_r && o_err_r, !o_nbv_r && o_last_r, "error word carries a neighbor")

endmodule

`default_nettype wire
